FILE: rtl/core/hla_pkg.sv
`default_nettype none

package hla_pkg;

    // default fraction width of the internal fixed-point datapath
    localparam int FRAC_BITS_DEF = 16;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;

    // lightness step register: fraction with STEP_FRAC fractional bits
    localparam int              STEP_W     = 17;
    localparam int              STEP_FRAC  = 16;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd16384;

    // divider geometry (numerator = value << FRAC_BITS, value < 2^11)
    localparam int DIV_DEN_W    = 9;
    localparam int DIV_VAL_W    = 11;
    localparam int DIV_NUM_W_DEF = FRAC_BITS_DEF + DIV_VAL_W;
    localparam int DIV_QUO_W_DEF = FRAC_BITS_DEF + 3;

    typedef enum logic {
        REQ_LIGHTEN = 1'b0,
        REQ_DARKEN  = 1'b1
    } t_req;

    // region of the hue-to-channel rule
    typedef enum logic [1:0] {
        HM_RAMP,
        HM_Q,
        HM_P
    } t_hmode;

endpackage

`default_nettype wire

FILE: rtl/core/hla_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Requires i_num < (i_den << QUO_W).
module hla_div import hla_pkg::*; #(
    parameter int NUM_W = DIV_NUM_W_DEF,
    parameter int DEN_W = DIV_DEN_W,
    parameter int QUO_W = DIV_QUO_W_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_rem [1:QUO_W];
    logic [DEN_W-1:0] r_den [1:QUO_W];
    logic [QUO_W-1:0] r_quo [1:QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] dsh;
        logic             ge;

        if (i == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[i];
            assign den_in = r_den[i];
            assign quo_in = r_quo[i];
        end

        assign dsh = NUM_W'(den_in) << (QUO_W - 1 - i);
        assign ge  = (rem_in >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= ge ? (rem_in - dsh) : rem_in;
                r_den[i+1] <= den_in;
                r_quo[i+1] <= quo_in | (QUO_W'(ge) << (QUO_W - 1 - i));
            end
        end
    end

    assign o_quo = r_quo[QUO_W];

endmodule

`default_nettype wire

FILE: rtl/core/hls_lightness_adjust_unit.sv
// Lighten or darken one packed RGB pixel in HSL space.
// Input stream (i_s_*): tdata carries the colour (red 7:0, green 15:8, blue 23:16),
//   tuser carries the request type (0 lighten, 1 darken). A request is taken at a
//   clock edge where i_s_tvalid and o_s_tready are both high.
// Output stream (o_m_*): tdata carries the adjusted colour in the same packing.
// Config: i_cfg_wr_en/i_cfg_wr_data write the lightness step (16 fractional bits),
//   reset value 0.25. Write only while no request is in flight.
// Throughput: one request per clock while o_s_tready is high, fully pipelined.
// Path: from the accepting edge to o_m_tvalid a request passes the input register,
//   prep, the two parallel bit-per-stage dividers (saturation, hue), FRAC_BITS + 3
//   stages long, then adjust, l*s multiply, p/q build, hue-channel multiply and the
//   output register. Lightness (sum / 510) comes from a reciprocal multiply and
//   rides a delay line of the same length as the dividers.
// Stall: a result waiting at the output does not stop the pipe; one more result
//   parks in a skid register, and only then does o_s_tready drop and the whole
//   pipe freeze. Nothing is lost or repeated.
// Reset (synchronous, active low): all valid bits clear, step returns to 0.25.
`default_nettype none

module hls_lightness_adjust_unit import hla_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // lightness step write
    input  wire logic               i_cfg_wr_en,
    input  wire logic [STEP_W-1:0]  i_cfg_wr_data,
    // request in
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [COLOR_W-1:0] i_s_tdata,   // [23:0] color_in
    input  wire logic               i_s_tuser,   // [0] req_type
    // result out
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic      [COLOR_W-1:0] o_m_tdata    // [23:0] color_out
);

    localparam int NUM_W = FRAC_BITS + DIV_VAL_W;
    localparam int QUO_W = FRAC_BITS + 3;
    localparam int LW    = FRAC_BITS + 1;   // l, s, ls in [0, ONE]
    localparam int HW    = FRAC_BITS + 3;   // hue in [0, 6*ONE)
    localparam int SW    = FRAC_BITS + 2;   // step after scaling
    localparam int W     = FRAC_BITS + 4;   // signed p/q/t datapath
    localparam int PW    = 2 * W;
    localparam int UP    = (FRAC_BITS >= STEP_FRAC) ? FRAC_BITS - STEP_FRAC : 0;
    localparam int DN    = (FRAC_BITS <  STEP_FRAC) ? STEP_FRAC - FRAC_BITS : 0;

    // sum * ONE / 510 as (sum * L_MUL) >> LM_SH, exact for sum <= 510
    localparam int              LM_SH = 18;
    localparam int              LM_W  = FRAC_BITS + 10;
    localparam int              LP_W  = FRAC_BITS + 19;
    localparam longint          LM_K  = ((longint'(1) << (FRAC_BITS + LM_SH)) + 509) / 510;
    localparam logic [LM_W-1:0] L_MUL = LM_W'(LM_K);

    localparam logic signed [W-1:0] ONE  = signed'(W'(1) << FRAC_BITS);
    localparam logic signed [W-1:0] TWO  = signed'(W'(2) << FRAC_BITS);
    localparam logic signed [W-1:0] THR  = signed'(W'(3) << FRAC_BITS);
    localparam logic signed [W-1:0] FOUR = signed'(W'(4) << FRAC_BITS);
    localparam logic signed [W-1:0] SIX  = signed'(W'(6) << FRAC_BITS);
    localparam logic [LW:0]         ONE_U = (LW+1)'(1) << FRAC_BITS;

    logic en;   // whole pipe advances

    // ---------------- config ----------------
    logic [STEP_W-1:0]    r_step;
    logic [STEP_W+UP-1:0] step_wide;
    logic [SW-1:0]        step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_wr_en) begin
            r_step <= i_cfg_wr_data;
        end
    end

    assign step_wide = (STEP_W+UP)'(r_step) << UP;
    assign step      = SW'(step_wide >> DN);

    // ---------------- S0: input register ----------------
    logic               r_s0_vld;
    logic               r_s0_req;
    logic [COLOR_W-1:0] r_s0_clr;

    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_req <= i_s_tuser;
            r_s0_clr <= i_s_tdata;
        end
    end

    // ---------------- S1: max/min, sector, divider operands ----------------
    logic [CHAN_W-1:0]     cr, cg, cb, mx, mn, dd;
    logic [8:0]            sum, den;
    logic signed [11:0]    nh;
    logic [NUM_W-1:0]      n_num_s, n_num_h;
    logic [DIV_DEN_W-1:0]  n_den_s, n_den_h;

    always_comb begin
        cr = r_s0_clr[7:0];
        cg = r_s0_clr[15:8];
        cb = r_s0_clr[23:16];
        mx = (cr > cg) ? cr : cg;
        if (cb > mx) mx = cb;
        mn = (cr < cg) ? cr : cg;
        if (cb < mn) mn = cb;
        sum = {1'b0, mx} + {1'b0, mn};
        dd  = mx - mn;
        den = (sum <= 9'd255) ? sum : (9'd510 - sum);
        priority if (cr == mx) begin
            nh = signed'(12'(cg)) - signed'(12'(cb));
        end else if (cg == mx) begin
            nh = (signed'(12'(dd)) <<< 1) + signed'(12'(cb)) - signed'(12'(cr));
        end else begin
            nh = (signed'(12'(dd)) <<< 2) + signed'(12'(cr)) - signed'(12'(cg));
        end
        if (nh < 0) nh = nh + signed'(12'(dd)) * 12'sd6;
        n_num_s = NUM_W'(dd) << FRAC_BITS;
        n_num_h = NUM_W'(nh[10:0]) << FRAC_BITS;
        // grey: force quotient 0 instead of dividing by zero
        n_den_s = (dd == '0) ? 9'd1 : den;
        n_den_h = (dd == '0) ? 9'd1 : {1'b0, dd};
    end

    logic                 r_s1_vld;
    logic                 r_s1_req;
    logic [8:0]           r_s1_sum;
    logic [NUM_W-1:0]     r_s1_num_s, r_s1_num_h;
    logic [DIV_DEN_W-1:0] r_s1_den_s, r_s1_den_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_req   <= r_s0_req;
            r_s1_sum   <= sum;
            r_s1_num_s <= n_num_s;
            r_s1_num_h <= n_num_h;
            r_s1_den_s <= n_den_s;
            r_s1_den_h <= n_den_h;
        end
    end

    // ---------------- dividers ----------------
    logic [QUO_W-1:0] quo_s, quo_h;

    hla_div #(.NUM_W(NUM_W), .DEN_W(DIV_DEN_W), .QUO_W(QUO_W)) u_div_s (
        .i_clk(i_clk), .i_en(en), .i_num(r_s1_num_s), .i_den(r_s1_den_s), .o_quo(quo_s)
    );
    hla_div #(.NUM_W(NUM_W), .DEN_W(DIV_DEN_W), .QUO_W(QUO_W)) u_div_h (
        .i_clk(i_clk), .i_en(en), .i_num(r_s1_num_h), .i_den(r_s1_den_h), .o_quo(quo_h)
    );

    // lightness: reciprocal multiply, then delayed to line up with the dividers
    logic [LP_W-1:0] l_prod;
    logic [LW-1:0]   r_dl [QUO_W];

    assign l_prod = LP_W'(r_s1_sum) * LP_W'(L_MUL);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0] <= l_prod[FRAC_BITS+LM_SH:LM_SH];
            for (int k = 1; k < QUO_W; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // valid and request type ride alongside the divider stages
    logic [QUO_W-1:0] r_dv, r_dreq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (en) begin
            r_dv <= {r_dv[QUO_W-2:0], r_s1_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dreq <= {r_dreq[QUO_W-2:0], r_s1_req};
        end
    end

    // ---------------- A: lightness adjust ----------------
    logic [LW-1:0] l_div, n_a_l;
    logic [LW+1:0] l_up;

    always_comb begin
        l_div = r_dl[QUO_W-1];
        l_up  = (LW+2)'(l_div) + (LW+2)'(step);
        if (t_req'(r_dreq[QUO_W-1]) == REQ_DARKEN) begin
            n_a_l = ((LW+2)'(step) > (LW+2)'(l_div)) ? '0 : LW'((LW+2)'(l_div) - (LW+2)'(step));
        end else begin
            n_a_l = (l_up > (LW+2)'(ONE_U)) ? LW'(ONE_U) : LW'(l_up);
        end
    end

    logic          r_a_vld;
    logic [LW-1:0] r_a_l, r_a_s;
    logic [HW-1:0] r_a_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= r_dv[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_l <= n_a_l;
            r_a_s <= quo_s[LW-1:0];
            r_a_h <= quo_h[HW-1:0];
        end
    end

    // ---------------- B: l*s ----------------
    logic [2*LW-1:0] ls_prod;
    assign ls_prod = r_a_l * r_a_s;

    logic          r_b_vld;
    logic [LW-1:0] r_b_l, r_b_s, r_b_ls;
    logic [HW-1:0] r_b_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_l  <= r_a_l;
            r_b_s  <= r_a_s;
            r_b_ls <= ls_prod[2*FRAC_BITS:FRAC_BITS];
            r_b_h  <= r_a_h;
        end
    end

    // ---------------- C: p, q, channel hues ----------------
    // grey (s = 0) gives p = q = l, so every channel lands on l
    logic signed [W-1:0] lw, sw, lsw, hw, n_q, n_p, n_tr, n_tb;

    always_comb begin
        lw  = signed'(W'(r_b_l));
        sw  = signed'(W'(r_b_s));
        lsw = signed'(W'(r_b_ls));
        hw  = signed'(W'(r_b_h));
        n_q = ((lw <<< 1) < ONE) ? (lw + lsw) : (lw + sw - lsw);
        n_p = (lw <<< 1) - n_q;
        n_tr = hw + TWO;
        if (n_tr > SIX) n_tr = n_tr - SIX;
        n_tb = hw - TWO;
        if (n_tb < 0) n_tb = n_tb + SIX;
    end

    logic                r_c_vld;
    logic signed [W-1:0] r_c_p, r_c_q;
    logic signed [W-1:0] r_c_t [3];   // red, green, blue

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_p    <= n_p;
            r_c_q    <= n_q;
            r_c_t[0] <= n_tr;
            r_c_t[1] <= hw;
            r_c_t[2] <= n_tb;
        end
    end

    // ---------------- D: hue-to-channel multiply ----------------
    logic signed [W-1:0]  diff;
    logic signed [W-1:0]  mul_m  [3];
    t_hmode               n_mode [3];
    logic signed [PW-1:0] n_prod [3];

    assign diff = r_c_q - r_c_p;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            priority if (r_c_t[k] < ONE) begin
                n_mode[k] = HM_RAMP;
                mul_m[k]  = r_c_t[k];
            end else if (r_c_t[k] < THR) begin
                n_mode[k] = HM_Q;
                mul_m[k]  = '0;
            end else if (r_c_t[k] < FOUR) begin
                n_mode[k] = HM_RAMP;
                mul_m[k]  = FOUR - r_c_t[k];
            end else begin
                n_mode[k] = HM_P;
                mul_m[k]  = '0;
            end
            n_prod[k] = PW'(diff) * PW'(mul_m[k]);
        end
    end

    logic                 r_d_vld;
    logic signed [W-1:0]  r_d_p, r_d_q;
    t_hmode               r_d_mode [3];
    logic signed [PW-1:0] r_d_prod [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_p    <= r_c_p;
            r_d_q    <= r_c_q;
            r_d_mode <= n_mode;
            r_d_prod <= n_prod;
        end
    end

    // ---------------- E: channel value to byte ----------------
    logic signed [W-1:0]   chan [3];
    logic signed [W+8:0]   scaled [3];
    logic signed [W+8:0]   byte_v [3];
    logic [CHAN_W-1:0]     chan_b [3];
    logic [COLOR_W-1:0]    pix;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            unique case (r_d_mode[k])
                HM_RAMP: chan[k] = r_d_p + W'(r_d_prod[k] >>> FRAC_BITS);
                HM_Q:    chan[k] = r_d_q;
                HM_P:    chan[k] = r_d_p;
                default: chan[k] = r_d_p;
            endcase
            if (chan[k] < 0) chan[k] = '0;
            // c * 255 as (c << 8) - c
            scaled[k] = ((W+9)'(chan[k]) <<< 8) - (W+9)'(chan[k]);
            byte_v[k] = scaled[k] >>> FRAC_BITS;
            chan_b[k] = (byte_v[k] > (W+9)'(255)) ? 8'hFF : byte_v[k][7:0];
        end
        pix = {chan_b[2], chan_b[1], chan_b[0]};
    end

    // ---------------- output register + skid ----------------
    logic               r_out_vld, r_skid_vld;
    logic [COLOR_W-1:0] r_out, r_skid;
    logic               out_free;

    assign en       = !r_skid_vld;
    assign out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_free) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (out_free) begin
            r_out_vld <= r_d_vld;
        end else if (r_d_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= pix;
        end else begin
            r_skid <= pix;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/hla_chk.sv
`default_nettype none

module hla_chk import hla_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_s_tready,
    input wire logic               o_m_tvalid,
    input wire logic               i_m_tready,
    input wire logic [COLOR_W-1:0] o_m_tdata
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset did not clear the pipe");

    // input only blocked while a result is parked at the output
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input blocked with no result waiting");

    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("ready dropped without an output stall");

endmodule

bind hls_lightness_adjust_unit hla_chk u_hla_chk (.*);

`default_nettype wire

FILE: bench/hls_lightness_adjust_unit_tb.sv
`default_nettype none

module hls_lightness_adjust_unit_tb;
    import hla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int LATENCY    = FB + 9;
    localparam int WATCHDOG   = 20000;
    localparam int N_RANDOM   = 1150;

    typedef struct packed {
        t_req               kind;
        logic [COLOR_W-1:0] color;
    } t_pixel_req;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [STEP_W-1:0]  i_cfg_wr_data;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [COLOR_W-1:0] i_s_tdata;   // [23:0] color_in
    logic               i_s_tuser;   // [0] req_type
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [COLOR_W-1:0] o_m_tdata;   // [23:0] color_out

    hls_lightness_adjust_unit #(.FRAC_BITS(FB)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    // predictor state: mirror of the step register
    logic [STEP_W-1:0]  step_reg;
    t_pixel_req         pending_reqs[$];
    logic [COLOR_W-1:0] expected_colors[$];
    int                 n_errors;
    bit                 calm;        // no random idling on either side
    bit                 hold_sink;   // long receiver hold-off requested
    int                 hold_cycles;
    int                 quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic longint hue_to_chan(longint p, longint q, longint t6);
        longint one;
        one = longint'(1) << FB;
        if (t6 < one)     return p + (((q - p) * t6) >>> FB);
        if (t6 < 3 * one) return q;
        if (t6 < 4 * one) return p + (((q - p) * (4 * one - t6)) >>> FB);
        return p;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_byte(longint c);
        longint v;
        if (c < 0) c = 0;
        v = (c * 255) >>> FB;
        if (v > 255) v = 255;
        return v[CHAN_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] adjust_color(t_pixel_req rq);
        longint one, r, g, b, mx, mn, sum, d, l, s, h6, stp, den, n, ls, q, p, tr, tb;
        logic [CHAN_W-1:0] ro, go, bo;
        one = longint'(1) << FB;
        r = rq.color[7:0];
        g = rq.color[15:8];
        b = rq.color[23:16];
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        sum = mx + mn;
        d = mx - mn;
        l = (sum << FB) / 510;
        s = 0;
        h6 = 0;
        if (d != 0) begin
            den = (sum <= 255) ? sum : (510 - sum);
            s = (d << FB) / den;
            if (r == mx)      n = g - b;
            else if (g == mx) n = 2 * d + (b - r);
            else              n = 4 * d + (r - g);
            if (n < 0) n += 6 * d;
            h6 = (n << FB) / d;
        end
        if (FB >= STEP_FRAC) stp = longint'(step_reg) << (FB - STEP_FRAC);
        else                 stp = longint'(step_reg) >> (STEP_FRAC - FB);
        if (rq.kind == REQ_DARKEN) begin
            l = l - stp;
            if (l < 0) l = 0;
        end else begin
            l = l + stp;
            if (l > one) l = one;
        end
        if (s == 0) begin
            ro = chan_byte(l);
            go = ro;
            bo = ro;
        end else begin
            ls = (l * s) >>> FB;
            q = (2 * l < one) ? (l + ls) : (l + s - ls);
            p = 2 * l - q;
            tr = h6 + 2 * one;
            tb = h6 - 2 * one;
            if (tr > 6 * one) tr -= 6 * one;   // exactly one turn is kept, not wrapped
            if (tb < 0) tb += 6 * one;
            ro = chan_byte(hue_to_chan(p, q, tr));
            go = chan_byte(hue_to_chan(p, q, h6));
            bo = chan_byte(hue_to_chan(p, q, tb));
        end
        return {bo, go, ro};
    endfunction

    // ---------------- driver ----------------
    // The request is predicted at the accepting edge so the step in force is the one used.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_colors = {expected_colors,
                                   adjust_color({t_req'(i_s_tuser), i_s_tdata})};
                void'(pending_reqs.pop_front());
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_reqs[0].color;
                    i_s_tuser  <= pending_reqs[0].kind;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor / sink ----------------
    always @(posedge i_clk) begin
        logic [COLOR_W-1:0] exp_color;
        if (!i_rst_n) begin
            i_m_tready  <= 1'b0;
            hold_cycles <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_colors.size() == 0) begin
                    $error("color_out: unexpected result %h", o_m_tdata);
                    n_errors++;
                end else begin
                    exp_color = expected_colors.pop_front();
                    if (o_m_tdata !== exp_color) begin
                        $error("color_out: expected %h actual %h", exp_color, o_m_tdata);
                        n_errors++;
                    end
                end
            end
            if (hold_sink && hold_cycles < 400) begin
                hold_cycles <= hold_cycles + 1;
                i_m_tready  <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(99) >= 20);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG) begin
                $display("hls_lightness_adjust_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [COLOR_W-1:0] rand_color();
        logic [CHAN_W-1:0] c0, c1, c2;
        c0 = CHAN_W'($urandom);
        c1 = CHAN_W'($urandom);
        c2 = CHAN_W'($urandom);
        case ($urandom_range(9))
            0: return {c0, c0, c0};       // grey
            1: return {c0, c1, c1};       // two equal channels
            2: return {c0, c0, c2};
            3: return {8'hFF, c1, 8'h00}; // full span
            default: return {c2, c1, c0};
        endcase
    endfunction

    task automatic push_req(t_req kind, logic [COLOR_W-1:0] color);
        t_pixel_req rq;
        rq.kind  = kind;
        rq.color = color;
        pending_reqs = {pending_reqs, rq};
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || i_s_tvalid || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_step(logic [STEP_W-1:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        step_reg = val;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++)
            push_req(t_req'($urandom_range(1)), rand_color());
    endtask

    initial begin
        logic [STEP_W-1:0] steps[6];
        n_errors      = 0;
        calm          = 1'b0;
        hold_sink     = 1'b0;
        step_reg      = STEP_RESET;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = 1'b0;
        i_m_tready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset step, extremes, greys, hue edges
        push_req(REQ_LIGHTEN, 24'h000000);
        push_req(REQ_DARKEN,  24'h000000);
        push_req(REQ_LIGHTEN, 24'hFFFFFF);
        push_req(REQ_DARKEN,  24'hFFFFFF);
        push_req(REQ_LIGHTEN, 24'h808080);
        push_req(REQ_DARKEN,  24'h7F7F7F);
        push_req(REQ_LIGHTEN, 24'h0000FF);
        push_req(REQ_DARKEN,  24'h00FF00);
        push_req(REQ_LIGHTEN, 24'hFF0000);
        push_req(REQ_DARKEN,  24'hFF00FF);  // magenta: hue near one turn
        push_req(REQ_LIGHTEN, 24'hFF00FE);
        push_req(REQ_DARKEN,  24'hFFFF00);
        push_req(REQ_LIGHTEN, 24'h00FFFF);
        push_req(REQ_DARKEN,  24'h010001);
        push_req(REQ_LIGHTEN, 24'hAA55AA);
        push_req(REQ_DARKEN,  24'h123456);
        drain();

        // step above one saturates both ways
        write_step(17'h1FFFF);
        push_req(REQ_LIGHTEN, 24'h336699);
        push_req(REQ_DARKEN,  24'h336699);
        push_req(REQ_LIGHTEN, 24'h808080);
        push_req(REQ_DARKEN,  24'hFEFFFE);
        drain();

        // random phases across settings, one with a long sink hold-off
        steps = '{17'd0, 17'd65536, 17'd1, 17'd16384, 17'd0, 17'd0};
        steps[4] = STEP_W'($urandom_range(65536));
        steps[5] = STEP_W'($urandom);
        for (int ph = 0; ph < 6; ph++) begin
            write_step(steps[ph]);
            calm = (ph == 2);
            hold_sink = (ph == 3);
            random_phase(N_RANDOM / 6);
            drain();
            hold_sink = 1'b0;
        end

        drain();
        if (n_errors == 0) begin
            $display("hls_lightness_adjust_unit_tb OK");
        end else begin
            $display("hls_lightness_adjust_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
